// ----- rtl/core/fbpa_pkg.sv -----
// fbpa_pkg: shared types, field widths and codes of the fixed block pool allocator
// used by every module under rtl/core; depends on nothing
`default_nettype none

package fbpa_pkg;

  localparam int unsigned ADDR_W       = 20;
  localparam int unsigned OBJ_W        = 16;
  localparam logic [15:0] OBJ_RESET    = 16'd64;
  localparam int unsigned CHUNK_BYTES  = 65536;
  localparam int unsigned BLOCK_ALIGN  = 64;
  localparam int unsigned BLK_SHIFT    = $clog2(BLOCK_ALIGN);
  localparam int unsigned OFF_W        = $clog2(CHUNK_BYTES);
  localparam int unsigned CHUNK_W      = ADDR_W - OFF_W;
  localparam int unsigned UNITS_W      = OFF_W - BLK_SHIFT;
  localparam int unsigned SLOT_W       = UNITS_W;
  localparam int unsigned UNIT_W       = OBJ_W + 1 - BLK_SHIFT;
  localparam int unsigned USABLE_UNITS = (CHUNK_BYTES - BLOCK_ALIGN) / BLOCK_ALIGN;

  localparam int unsigned SLOT_DEPTH   = 16384;
  localparam int unsigned IDX_W        = $clog2(SLOT_DEPTH);
  localparam int unsigned LINK_W       = IDX_W + 1;
  localparam int unsigned RECIP_NUM    = SLOT_DEPTH;
  localparam int unsigned RECIP_W      = IDX_W + 1;

  localparam int unsigned USE_ROW_W    = 32;
  localparam int unsigned USE_ROWS     = SLOT_DEPTH / USE_ROW_W;
  localparam int unsigned ROW_IDX_W    = $clog2(USE_ROWS);
  localparam int unsigned BIT_IDX_W    = $clog2(USE_ROW_W);

  localparam int unsigned DIV_NUM_W    = RECIP_W;
  localparam int unsigned DIV_DEN_W    = UNIT_W;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_NUM_W + 1);

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OOM        = 2'd1,
    ST_NOT_BLOCK  = 2'd2,
    ST_NOT_IN_USE = 2'd3
  } fbpa_status_e;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
  } fbpa_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    fbpa_status_e      status;
  } fbpa_out_t;

  typedef struct packed {
    logic [UNIT_W-1:0]  unit;
    logic [SLOT_W-1:0]  slots;
    logic [RECIP_W-1:0] recip_unit;
    logic [RECIP_W-1:0] recip_slots;
  } fbpa_geom_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } fbpa_core_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/fbpa_div.sv -----
// fbpa_div: restoring divider, one quotient bit per cycle
// depends on fbpa_pkg
`default_nettype none

module fbpa_div import fbpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quo_o
);

  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   trial_sub;
  logic                 ge;

  assign trial     = {rem_q, quo_q[DIV_NUM_W-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DIV_CNT_W'(DIV_NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - DIV_CNT_W'(1);
        done_q <= (cnt_q == DIV_CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ----- rtl/core/fbpa_geom.sv -----
// fbpa_geom: object size register and derived block geometry (slots, reciprocals)
// depends on fbpa_pkg and fbpa_div
`default_nettype none

module fbpa_geom import fbpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [OBJ_W-1:0] cfg_data_i,
  output fbpa_geom_t       geom_o,
  output logic             busy_o
);

  localparam logic [2:0] GS_IDLE  = 3'd0;
  localparam logic [2:0] GS_START = 3'd1;
  localparam logic [2:0] GS_SLOTS = 3'd2;
  localparam logic [2:0] GS_RU    = 3'd3;
  localparam logic [2:0] GS_RS    = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [OBJ_W-1:0]     obj_q;
  logic [SLOT_W-1:0]    slots_q;
  logic [RECIP_W-1:0]   ru_q;
  logic [RECIP_W-1:0]   rs_q;
  logic [OBJ_W:0]       obj_round;
  logic [UNIT_W-1:0]    unit_raw;
  logic [UNIT_W-1:0]    unit;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  assign obj_round = (OBJ_W+1)'(obj_q) + (OBJ_W+1)'(BLOCK_ALIGN - 1);
  assign unit_raw  = obj_round[OBJ_W:BLK_SHIFT];
  assign unit      = (unit_raw == '0) ? UNIT_W'(1) : unit_raw;

  fbpa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = DIV_NUM_W'(RECIP_NUM);
    div_den   = unit;
    unique case (state_q)
      GS_START: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(USABLE_UNITS);
        state_d   = GS_SLOTS;
      end
      GS_SLOTS: begin
        if (div_done) begin
          div_start = 1'b1;
          state_d   = GS_RU;
        end
      end
      GS_RU: begin
        if (div_done) begin
          if (slots_q != '0) begin
            div_start = 1'b1;
            div_den   = DIV_DEN_W'(slots_q);
            state_d   = GS_RS;
          end else begin
            state_d = GS_IDLE;
          end
        end
      end
      GS_RS: begin
        if (div_done) begin
          state_d = GS_IDLE;
        end
      end
      GS_IDLE: begin
        state_d = GS_IDLE;
      end
      default: begin
        state_d = GS_START;
      end
    endcase
    if (cfg_we_i) begin
      div_start = 1'b0;
      state_d   = GS_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GS_START;
      obj_q   <= OBJ_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        obj_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done && state_q == GS_SLOTS) begin
      slots_q <= div_quo[SLOT_W-1:0];
    end
    if (div_done && state_q == GS_RU) begin
      ru_q <= div_quo;
      if (slots_q == '0) begin
        rs_q <= '0;
      end
    end
    if (div_done && state_q == GS_RS) begin
      rs_q <= div_quo;
    end
  end

  assign geom_o.unit        = unit;
  assign geom_o.slots       = slots_q;
  assign geom_o.recip_unit  = ru_q;
  assign geom_o.recip_slots = rs_q;
  assign busy_o             = (state_q != GS_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/fbpa_core.sv -----
// fbpa_core: request sequencer with the link store and the packed in-use store
// depends on fbpa_pkg; geometry comes from fbpa_geom
`default_nettype none

module fbpa_core import fbpa_pkg::*; #(
  parameter int unsigned MAX_CHUNKS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  fbpa_in_t        req_i,
  input  fbpa_geom_t      geom_i,
  input  logic            res_take_i,
  output fbpa_core_stat_t stat_o,
  output fbpa_out_t       res_o
);

  localparam int unsigned CG_W   = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned BASE_W = ((CG_W + SLOT_W > IDX_W) ? CG_W + SLOT_W : IDX_W) + 1;
  localparam int unsigned CMP_W  = (CG_W > CHUNK_W) ? CG_W : CHUNK_W;
  localparam int unsigned P1_W   = IDX_W + RECIP_W;
  localparam int unsigned P2_W   = IDX_W + UNIT_W;
  localparam int unsigned OU_W   = 2 * UNIT_W;
  localparam int unsigned IDXF_W = IDX_W + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_G_MUL  = 4'd1;
  localparam logic [3:0] S_G_CHK  = 4'd2;
  localparam logic [3:0] S_G_FILL = 4'd3;
  localparam logic [3:0] S_A_RD   = 4'd4;
  localparam logic [3:0] S_A_WB   = 4'd5;
  localparam logic [3:0] S_A_FIX  = 4'd6;
  localparam logic [3:0] S_A_ADR  = 4'd7;
  localparam logic [3:0] S_R_DIV1 = 4'd8;
  localparam logic [3:0] S_R_DIV2 = 4'd9;
  localparam logic [3:0] S_R_FIX  = 4'd10;
  localparam logic [3:0] S_R_IDX  = 4'd11;
  localparam logic [3:0] S_R_CHK  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  localparam logic [LINK_W-1:0] NULL_LINK = {1'b1, {IDX_W{1'b0}}};

  logic [3:0]           state_q, state_d;
  logic [LINK_W-1:0]    free_head_q, free_head_d;
  logic [CG_W-1:0]      cg_q, cg_d;
  logic                 clr_busy_q;
  logic [ROW_IDX_W-1:0] clr_cnt_q;

  logic                 kind_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [BASE_W-1:0]    base_q;
  logic [IDX_W-1:0]     fill_addr_q;
  logic [SLOT_W-1:0]    fill_left_q;
  logic [IDX_W-1:0]     n_q;
  logic [P1_W-1:0]      p1_q;
  logic [P2_W-1:0]      p2_q;
  logic [IDX_W-1:0]     qe_q;
  logic [IDX_W-1:0]     q_q;
  logic [UNIT_W-1:0]    r_q;
  logic [IDX_W-1:0]     s_q;
  fbpa_out_t            res_q, res_d;

  logic [LINK_W-1:0]    link_mem [SLOT_DEPTH];
  logic [LINK_W-1:0]    link_rdata_q;
  logic                 link_we, link_re;
  logic [IDX_W-1:0]     link_waddr, link_raddr;
  logic [LINK_W-1:0]    link_wdata;

  logic [USE_ROW_W-1:0] use_mem [USE_ROWS];
  logic [USE_ROW_W-1:0] use_rdata_q;
  logic                 use_we, use_re;
  logic [ROW_IDX_W-1:0] use_waddr, use_raddr;
  logic [USE_ROW_W-1:0] use_wdata;
  logic [USE_ROW_W-1:0] use_mask;

  logic                 is_alloc;
  logic [RECIP_W-1:0]   m_cur;
  logic [UNIT_W-1:0]    d_cur;
  logic [IDX_W-1:0]     n_cur;
  logic [P1_W-1:0]      p1_d;
  logic [IDX_W-1:0]     qe_cur;
  logic [P2_W-1:0]      p2_d;
  logic [IDX_W-1:0]     r_raw;
  logic [IDX_W-1:0]     r_sub;
  logic                 fix;
  logic [OU_W-1:0]      off_prod;
  logic [ADDR_W-1:0]    alloc_addr;
  logic [CHUNK_W-1:0]   rel_chunk;
  logic [IDXF_W-1:0]    idx_full;
  logic                 rel_bad;
  logic                 grow_fail;
  logic [BASE_W-1:0]    base_d;
  logic                 use_bit;

  assign is_alloc = (kind_q == KIND_ALLOC);
  assign m_cur    = is_alloc ? geom_i.recip_slots : geom_i.recip_unit;
  assign d_cur    = is_alloc ? UNIT_W'(geom_i.slots) : geom_i.unit;
  assign n_cur    = is_alloc ? free_head_q[IDX_W-1:0] : IDX_W'(addr_q[OFF_W-1:BLK_SHIFT]);
  assign p1_d     = P1_W'(n_cur) * P1_W'(m_cur);
  assign qe_cur   = p1_q[2*IDX_W-1:IDX_W];
  assign p2_d     = P2_W'(qe_cur) * P2_W'(d_cur);
  assign r_raw    = n_q - p2_q[IDX_W-1:0];
  assign fix      = r_raw >= IDX_W'(d_cur);
  assign r_sub    = r_raw - IDX_W'(d_cur);

  assign off_prod   = OU_W'(r_q) * OU_W'(geom_i.unit);
  assign alloc_addr = (geom_i.slots == '0) ? '0 :
                      {q_q[CHUNK_W-1:0], off_prod[UNITS_W-1:0], {BLK_SHIFT{1'b0}}};

  assign rel_chunk = addr_q[ADDR_W-1:OFF_W];
  assign idx_full  = IDXF_W'(rel_chunk) * IDXF_W'(geom_i.slots) + IDXF_W'(q_q);
  assign rel_bad   = (CMP_W'(rel_chunk) >= CMP_W'(cg_q)) ||
                     (addr_q[BLK_SHIFT-1:0] != '0) ||
                     (r_q != '0) ||
                     (addr_q[OFF_W-1:0] >= OFF_W'(CHUNK_BYTES - BLOCK_ALIGN)) ||
                     (q_q >= IDX_W'(geom_i.slots)) ||
                     idx_full[IDX_W];

  assign base_d    = BASE_W'(cg_q) * BASE_W'(geom_i.slots);
  assign grow_fail = (cg_q >= CG_W'(MAX_CHUNKS)) || (geom_i.slots == '0) ||
                     (base_q + BASE_W'(geom_i.slots) > BASE_W'(SLOT_DEPTH));

  assign use_mask = USE_ROW_W'(1) << s_q[BIT_IDX_W-1:0];
  assign use_bit  = use_rdata_q[s_q[BIT_IDX_W-1:0]];

  always_comb begin
    state_d     = state_q;
    free_head_d = free_head_q;
    cg_d        = cg_q;
    res_d       = res_q;
    link_we     = 1'b0;
    link_waddr  = s_q;
    link_wdata  = free_head_q;
    link_re     = 1'b0;
    link_raddr  = free_head_q[IDX_W-1:0];
    use_we      = 1'b0;
    use_waddr   = s_q[IDX_W-1:BIT_IDX_W];
    use_wdata   = use_rdata_q | use_mask;
    use_re      = 1'b0;
    use_raddr   = free_head_q[IDX_W-1:BIT_IDX_W];
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (req_i.kind == KIND_RELEASE) begin
            state_d = S_R_DIV1;
          end else if (free_head_q[IDX_W]) begin
            state_d = S_G_MUL;
          end else begin
            state_d = S_A_RD;
          end
        end
      end
      S_G_MUL: begin
        state_d = S_G_CHK;
      end
      S_G_CHK: begin
        if (grow_fail) begin
          res_d.block_address = '0;
          res_d.status        = ST_OOM;
          state_d             = S_DONE;
        end else begin
          state_d = S_G_FILL;
        end
      end
      S_G_FILL: begin
        link_we    = 1'b1;
        link_waddr = fill_addr_q;
        if (fill_left_q == SLOT_W'(1)) begin
          link_wdata  = free_head_q;
          free_head_d = {1'b0, base_q[IDX_W-1:0]};
          cg_d        = cg_q + CG_W'(1);
          state_d     = S_A_RD;
        end else begin
          link_wdata = {1'b0, fill_addr_q + IDX_W'(1)};
        end
      end
      S_A_RD: begin
        link_re = 1'b1;
        use_re  = 1'b1;
        state_d = S_A_WB;
      end
      S_A_WB: begin
        free_head_d = link_rdata_q;
        use_we      = 1'b1;
        use_wdata   = use_rdata_q | use_mask;
        state_d     = S_A_FIX;
      end
      S_A_FIX: begin
        state_d = S_A_ADR;
      end
      S_A_ADR: begin
        res_d.block_address = alloc_addr;
        res_d.status        = ST_OK;
        state_d             = S_DONE;
      end
      S_R_DIV1: begin
        state_d = S_R_DIV2;
      end
      S_R_DIV2: begin
        state_d = S_R_FIX;
      end
      S_R_FIX: begin
        state_d = S_R_IDX;
      end
      S_R_IDX: begin
        use_re    = 1'b1;
        use_raddr = idx_full[IDX_W-1:BIT_IDX_W];
        if (rel_bad) begin
          res_d.block_address = '0;
          res_d.status        = ST_NOT_BLOCK;
          state_d             = S_DONE;
        end else begin
          state_d = S_R_CHK;
        end
      end
      S_R_CHK: begin
        res_d.block_address = '0;
        if (!use_bit) begin
          res_d.status = ST_NOT_IN_USE;
        end else begin
          res_d.status = ST_OK;
          link_we      = 1'b1;
          link_waddr   = s_q;
          link_wdata   = free_head_q;
          use_we       = 1'b1;
          use_wdata    = use_rdata_q & ~use_mask;
          free_head_d  = {1'b0, s_q};
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (clr_busy_q) begin
      use_we    = 1'b1;
      use_waddr = clr_cnt_q;
      use_wdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= NULL_LINK;
      cg_q        <= '0;
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      cg_q        <= cg_d;
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + ROW_IDX_W'(1);
        if (clr_cnt_q == ROW_IDX_W'(USE_ROWS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == S_IDLE && req_valid_i) begin
      kind_q <= req_i.kind;
      addr_q <= req_i.address;
    end
    if (state_q == S_G_MUL) begin
      base_q <= base_d;
    end
    if (state_q == S_G_CHK) begin
      fill_addr_q <= base_q[IDX_W-1:0];
      fill_left_q <= geom_i.slots;
    end
    if (state_q == S_G_FILL) begin
      fill_addr_q <= fill_addr_q + IDX_W'(1);
      fill_left_q <= fill_left_q - SLOT_W'(1);
    end
    if (state_q == S_A_RD || state_q == S_R_DIV1) begin
      n_q  <= n_cur;
      p1_q <= p1_d;
    end
    if (state_q == S_A_RD) begin
      s_q <= free_head_q[IDX_W-1:0];
    end
    if (state_q == S_A_WB || state_q == S_R_DIV2) begin
      qe_q <= qe_cur;
      p2_q <= p2_d;
    end
    if (state_q == S_A_FIX || state_q == S_R_FIX) begin
      q_q <= fix ? qe_q + IDX_W'(1) : qe_q;
      r_q <= fix ? UNIT_W'(r_sub) : UNIT_W'(r_raw);
    end
    if (state_q == S_R_IDX) begin
      s_q <= idx_full[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rdata_q <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (use_we) begin
      use_mem[use_waddr] <= use_wdata;
    end
    if (use_re) begin
      use_rdata_q <= use_mem[use_raddr];
    end
  end

  assign stat_o.idle      = (state_q == S_IDLE) && !clr_busy_q;
  assign stat_o.res_valid = (state_q == S_DONE);
  assign res_o            = res_q;

endmodule

`default_nettype wire

// ----- rtl/core/fixed_block_pool_allocator_unit.sv -----
// fixed_block_pool_allocator_unit: top level of the fixed block pool allocator
// depends on fbpa_pkg, fbpa_geom, fbpa_core (and fbpa_div below fbpa_geom)
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------
//   request  | in_valid_i / in_stall_o | in_data_i  (kind, address)
//   result   | out_valid_o/ out_stall_i| out_data_o (block_address, status)
//   config   | cfg_we_i                | cfg_data_i (object_bytes)
//
// one transfer at a time: allocate runs A_RD, A_WB, A_FIX, A_ADR; release runs R_DIV1,
// R_DIV2, R_FIX, R_IDX, R_CHK (no R_CHK when the address is not a block); an allocate
// with an empty free list first runs G_MUL, G_CHK (to DONE if no chunk can grow), G_FILL
// (one link write per cycle); after reset the in-use store is cleared row by row, and
// a config write recomputes geometry on the serial divider, with requests stalled
// a waiting result sits in the output register while the next request is taken
`default_nettype none

module fixed_block_pool_allocator_unit import fbpa_pkg::*; #(
  parameter int unsigned MAX_CHUNKS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fbpa_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fbpa_out_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [OBJ_W-1:0] cfg_data_i
);

  fbpa_geom_t      geom;
  logic            geom_busy;
  fbpa_core_stat_t core_stat;
  fbpa_out_t       core_res;
  logic            accept;
  logic            out_free;
  logic            res_take;
  logic            out_valid_q;
  fbpa_out_t       out_data_q;

  assign in_stall_o = !core_stat.idle || geom_busy || cfg_we_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign res_take   = core_stat.res_valid && out_free;

  fbpa_geom u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .geom_o     (geom),
    .busy_o     (geom_busy)
  );

  fbpa_core #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (accept),
    .req_i       (in_data_i),
    .geom_i      (geom),
    .res_take_i  (res_take),
    .stat_o      (core_stat),
    .res_o       (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= core_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !core_stat.idle)
    else $error("core still idle after a request transfer");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.res_valid && out_free |=> out_valid_o)
    else $error("finished result not moved to the output register");

  a_output_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !core_stat.res_valid |=> !out_valid_o)
    else $error("output register kept a result that was already taken");

endmodule

`default_nettype wire
